/* hw/rtl/weno5_upwind_advection_step_unit_assert.svh */
// Assertion macros for the block's modules; only the core includes them.
`ifndef WENO5_UPWIND_ADVECTION_STEP_UNIT_ASSERT_SVH
`define WENO5_UPWIND_ADVECTION_STEP_UNIT_ASSERT_SVH

// Same-cycle implication.
`define W5_ASSERT_IMPL(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication.
`define W5_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

/* hw/rtl/w5adv_pkg.sv */
package w5adv_pkg;

	localparam int unsigned CFG_AW = 4;

	typedef enum logic [1:0] {
		REG_INV_Z = 2'd0,
		REG_INV_R = 2'd1,
		REG_TSTEP = 2'd2
	} reg_idx_t;

	localparam logic [31:0] INV_STEP_RST = 32'd65536;
	localparam logic [31:0] TSTEP_RST    = 32'd655;

	// 12e-6 in Q0.32.
	localparam logic [63:0] EPS_Q32 = 64'd51540;
	// ceil(2^56 / 6): exact division by six for magnitudes below 2^55.
	localparam logic [63:0] RECIP6  = 64'd12009599006321323;

	localparam logic [63:0] PHI_CAP   = 64'h4000_0000_0000_0000;
	localparam logic [63:0] TERM_CAP  = 64'h2000_0000_0000_0000;
	localparam logic [63:0] DELTA_CAP = 64'h0000_0100_0000_0000;

	typedef struct packed {
		logic [31:0] inv_z;
		logic [31:0] inv_r;
		logic [31:0] tstep;
	} cfg_t;

	typedef struct packed {
		logic        start;
		logic        div;
		logic [63:0] a;
		logic [63:0] b;
	} mdu_req_t;

	typedef struct packed {
		logic         busy;
		logic         done;
		logic [127:0] prod;
		logic [16:0]  quo;
	} mdu_rsp_t;

	// Q16.16 product scaling with a magnitude ceiling.
	function automatic logic [63:0] q16_sat(input logic [127:0] p, input logic [63:0] cap);
		logic [63:0] r;
		r = p[79:16];
		if (|p[127:80]) begin
			return cap;
		end
		return (r > cap) ? cap : r;
	endfunction

	function automatic logic [63:0] mag64(input logic signed [63:0] x);
		return x[63] ? (64'd0 - x) : x;
	endfunction

	function automatic logic signed [63:0] with_sign(input logic [63:0] m, input logic neg);
		return neg ? $signed(64'd0 - m) : $signed(m);
	endfunction

endpackage

/* hw/rtl/w5adv_regs.sv */
module w5adv_regs (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [w5adv_pkg::CFG_AW-1:0]      paddr,
	input  logic [31:0]                       pwdata,
	output logic [31:0]                       prdata,
	output logic                              pready,
	output w5adv_pkg::cfg_t                   cfg
);

	w5adv_pkg::cfg_t   cfg_q;
	w5adv_pkg::reg_idx_t idx;
	logic              wr_en;

	assign idx    = w5adv_pkg::reg_idx_t'(paddr[3:2]);
	assign wr_en  = psel & penable & pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.inv_z <= w5adv_pkg::INV_STEP_RST;
			cfg_q.inv_r <= w5adv_pkg::INV_STEP_RST;
			cfg_q.tstep <= w5adv_pkg::TSTEP_RST;
		end else if (wr_en) begin
			unique case (idx)
				w5adv_pkg::REG_INV_Z: cfg_q.inv_z <= pwdata;
				w5adv_pkg::REG_INV_R: cfg_q.inv_r <= pwdata;
				w5adv_pkg::REG_TSTEP: cfg_q.tstep <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			w5adv_pkg::REG_INV_Z: prdata = cfg_q.inv_z;
			w5adv_pkg::REG_INV_R: prdata = cfg_q.inv_r;
			w5adv_pkg::REG_TSTEP: prdata = cfg_q.tstep;
			default:              prdata = 32'd0;
		endcase
	end

endmodule

/* hw/rtl/w5adv_mdu.sv */
// Shared multiply/divide unit. A multiply runs one 32x32 partial product per
// cycle (one pass when both operands fit in 32 bits, four otherwise). A divide
// produces a 17-bit quotient, one bit per cycle, for dividends below 2^17
// times the divisor and divisors below 2^48.
module w5adv_mdu (
	input  logic                 clk,
	input  logic                 arst_n,
	input  w5adv_pkg::mdu_req_t  req,
	output w5adv_pkg::mdu_rsp_t  rsp
);

	typedef enum logic [2:0] {
		M_IDLE = 3'b001,
		M_MUL  = 3'b010,
		M_DIV  = 3'b100
	} mst_t;

	mst_t         st_q;
	logic [4:0]   cnt_q;
	logic [1:0]   last_q;
	logic         done_q;
	logic [63:0]  a_q;
	logic [63:0]  b_q;
	logic [127:0] acc_q;
	logic [63:0]  rem_q;
	logic [63:0]  dsh_q;
	logic [16:0]  quo_q;

	logic [31:0]  ah;
	logic [31:0]  bh;
	logic [63:0]  pp;
	logic [127:0] pp_sh;
	logic         ge;
	logic         go;

	assign go = (st_q == M_IDLE) && req.start;
	assign ah = cnt_q[1] ? a_q[63:32] : a_q[31:0];
	assign bh = cnt_q[0] ? b_q[63:32] : b_q[31:0];
	assign pp = {32'd0, ah} * {32'd0, bh};
	assign ge = rem_q >= dsh_q;

	always_comb begin
		case ({1'b0, cnt_q[1]} + {1'b0, cnt_q[0]})
			2'd0:    pp_sh = {64'd0, pp};
			2'd1:    pp_sh = {32'd0, pp, 32'd0};
			default: pp_sh = {pp, 64'd0};
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= M_IDLE;
			cnt_q  <= 5'd0;
			last_q <= 2'd0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (st_q)
				M_IDLE: begin
					if (go && req.div) begin
						st_q  <= M_DIV;
						cnt_q <= 5'd16;
					end else if (go) begin
						st_q   <= M_MUL;
						cnt_q  <= 5'd0;
						last_q <= ((|req.a[63:32]) || (|req.b[63:32])) ? 2'd3 : 2'd0;
					end
				end
				M_MUL: begin
					if (cnt_q[1:0] == last_q) begin
						st_q   <= M_IDLE;
						done_q <= 1'b1;
					end else begin
						cnt_q <= cnt_q + 5'd1;
					end
				end
				M_DIV: begin
					if (cnt_q == 5'd0) begin
						st_q   <= M_IDLE;
						done_q <= 1'b1;
					end else begin
						cnt_q <= cnt_q - 5'd1;
					end
				end
				default: st_q <= M_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			a_q   <= req.a;
			b_q   <= req.b;
			acc_q <= 128'd0;
			rem_q <= req.a;
			dsh_q <= {req.b[47:0], 16'd0};
			quo_q <= 17'd0;
		end else if (st_q == M_MUL) begin
			acc_q <= acc_q + pp_sh;
		end else if (st_q == M_DIV) begin
			if (ge) begin
				rem_q <= rem_q - dsh_q;
			end
			quo_q <= {quo_q[15:0], ge};
			dsh_q <= dsh_q >> 1;
		end
	end

	assign rsp.busy = (st_q != M_IDLE);
	assign rsp.done = done_q;
	assign rsp.prod = acc_q;
	assign rsp.quo  = quo_q;

endmodule

/* hw/rtl/w5adv_core.sv */
`include "weno5_upwind_advection_step_unit_assert.svh"

// Sequencer and datapath registers; every quotient and every product but those by
// small constants goes through the shared multiply/divide unit.
module w5adv_core (
	input  logic                 clk,
	input  logic                 arst_n,
	input  w5adv_pkg::cfg_t      cfg,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic                 axis,
	input  logic signed [31:0]   sample_m3,
	input  logic signed [31:0]   sample_m2,
	input  logic signed [31:0]   sample_m1,
	input  logic signed [31:0]   sample_center,
	input  logic signed [31:0]   sample_p1,
	input  logic signed [31:0]   sample_p2,
	input  logic signed [31:0]   sample_p3,
	input  logic signed [31:0]   face_vel_here,
	input  logic signed [31:0]   face_vel_below,
	input  logic                 at_low_edge,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic signed [31:0]   new_value,
	output w5adv_pkg::mdu_req_t  mdu_req,
	input  w5adv_pkg::mdu_rsp_t  mdu_rsp
);

	typedef enum logic [15:0] {
		ST_IDLE  = 16'h0001,
		ST_VMUL  = 16'h0002,
		ST_NUM   = 16'h0004,
		ST_DMUL  = 16'h0008,
		ST_NORM  = 16'h0010,
		ST_MU    = 16'h0020,
		ST_EPS   = 16'h0040,
		ST_ASQ   = 16'h0080,
		ST_BSQ   = 16'h0100,
		ST_QDIV  = 16'h0200,
		ST_QSQ   = 16'h0400,
		ST_OMDIV = 16'h0800,
		ST_PHI   = 16'h1000,
		ST_TERM  = 16'h2000,
		ST_DELTA = 16'h4000,
		ST_FIN   = 16'h8000
	} st_t;

	localparam logic [2:0] IDEAL_W [3] = '{3'd1, 3'd6, 3'd3};

	// Control state.
	st_t                 st_q;
	logic                issued_q;
	logic [2:0]          k_q;
	logic                out_valid_q;
	logic signed [63:0]  axial_q;

	// Item and intermediate values.
	logic signed [31:0]  s_q [7];
	logic                axis_q;
	logic signed [31:0]  vel_q;
	logic [47:0]         vmag_q [5];
	logic                vneg_q [5];
	logic signed [54:0]  num_q;
	logic signed [52:0]  data_q [3];
	logic [29:0]         mu2_q;
	logic [13:0]         eps_q;
	logic [37:0]         tacc_q;
	logic [39:0]         d_q [3];
	logic [16:0]         q_q;
	logic [34:0]         w_q [3];
	logic [16:0]         om_q;
	logic signed [55:0]  phi_q;
	logic signed [63:0]  sum_q;
	logic signed [31:0]  res_q;
	logic signed [31:0]  nv_q;

	logic signed [32:0]  vel_sum;
	logic signed [31:0]  vel_new;
	logic                vel_pos;
	logic signed [32:0]  dlo [5];
	logic signed [32:0]  dhi [5];
	logic signed [32:0]  diff_sel;
	logic signed [54:0]  ve [5];
	logic signed [54:0]  num_sel;
	logic                norm_big;
	logic [14:0]         mu;
	logic signed [19:0]  ue [5];
	logic signed [19:0]  a_all [3];
	logic signed [19:0]  b_all [3];
	logic [39:0]         dmin01;
	logic [39:0]         dmin;
	logic [35:0]         wsum;
	logic [63:0]         res_mag;
	logic                neg_sel;
	logic signed [63:0]  sgn_res;
	logic signed [42:0]  r_ext;
	logic signed [31:0]  r_sat;
	logic                op_st;
	logic                op_done;
	logic                fin_load;
	logic                accept;

	assign accept   = in_valid && in_ready;
	assign in_ready = (st_q == ST_IDLE);
	assign op_done  = issued_q && mdu_rsp.done;
	assign fin_load = (st_q == ST_FIN) && (!out_valid_q || out_ready);
	assign out_valid = out_valid_q;
	assign new_value = nv_q;

	// Cell velocity: floor of the face mean, zero on the low edge.
	assign vel_sum = 33'(face_vel_here) + 33'(face_vel_below);
	assign vel_new = at_low_edge ? 32'sd0 : vel_sum[32:1];
	assign vel_pos = !vel_q[31] && (vel_q != 32'sd0);

	always_comb begin
		for (int k = 0; k < 5; k++) begin
			dlo[k] = 33'(s_q[k + 1]) - 33'(s_q[k]);
			dhi[k] = 33'(s_q[6 - k]) - 33'(s_q[5 - k]);
			ve[k]  = vneg_q[k] ? -55'($signed({1'b0, vmag_q[k]}))
				: 55'($signed({1'b0, vmag_q[k]}));
			ue[k]  = vneg_q[k] ? -20'($signed({1'b0, vmag_q[k][14:0]}))
				: 20'($signed({1'b0, vmag_q[k][14:0]}));
		end
	end

	assign diff_sel = vel_pos ? dlo[k_q] : dhi[k_q];

	always_comb begin
		case (k_q[1:0])
			2'd0:    num_sel = ve[0] * 55'sd2 - ve[1] * 55'sd7 + ve[2] * 55'sd11;
			2'd1:    num_sel = ve[2] * 55'sd5 - ve[1] + ve[3] * 55'sd2;
			default: num_sel = ve[2] * 55'sd2 + ve[3] * 55'sd5 - ve[4];
		endcase
	end

	// Normalization keeps shifting until every magnitude is below 2^15.
	assign norm_big = |{vmag_q[0][47:15], vmag_q[1][47:15], vmag_q[2][47:15],
		vmag_q[3][47:15], vmag_q[4][47:15]};

	always_comb begin
		mu = 15'd0;
		for (int k = 0; k < 5; k++) begin
			if (vmag_q[k][14:0] > mu) begin
				mu = vmag_q[k][14:0];
			end
		end
	end

	// First and second differences of the three stencils.
	assign a_all[0] = ue[0] - ue[1] * 20'sd2 + ue[2];
	assign a_all[1] = ue[1] - ue[2] * 20'sd2 + ue[3];
	assign a_all[2] = ue[2] - ue[3] * 20'sd2 + ue[4];
	assign b_all[0] = ue[0] - ue[1] * 20'sd4 + ue[2] * 20'sd3;
	assign b_all[1] = ue[1] - ue[3];
	assign b_all[2] = ue[2] * 20'sd3 - ue[3] * 20'sd4 + ue[4];

	assign dmin01 = (d_q[1] < d_q[0]) ? d_q[1] : d_q[0];
	assign dmin   = (d_q[2] < dmin01) ? d_q[2] : dmin01;
	assign wsum   = 36'(w_q[0]) + 36'(w_q[1]) + 36'(w_q[2]);

	// Operand selection for the shared unit and shaping of its result.
	always_comb begin
		mdu_req.div = 1'b0;
		mdu_req.a   = 64'd0;
		mdu_req.b   = 64'd0;
		res_mag     = 64'd0;
		neg_sel     = 1'b0;
		op_st       = 1'b1;
		unique case (st_q)
			ST_VMUL: begin
				mdu_req.a = w5adv_pkg::mag64(64'(diff_sel));
				mdu_req.b = {32'd0, axis_q ? cfg.inv_r : cfg.inv_z};
			end
			ST_DMUL: begin
				mdu_req.a = w5adv_pkg::mag64(64'(num_q));
				mdu_req.b = w5adv_pkg::RECIP6;
				res_mag   = mdu_rsp.prod[119:56];
				neg_sel   = num_q[54];
			end
			ST_MU: begin
				mdu_req.a = {49'd0, mu};
				mdu_req.b = {49'd0, mu};
			end
			ST_EPS: begin
				mdu_req.a = {34'd0, mu2_q};
				mdu_req.b = w5adv_pkg::EPS_Q32;
			end
			ST_ASQ: begin
				mdu_req.a = w5adv_pkg::mag64(64'(a_all[k_q[1:0]]));
				mdu_req.b = w5adv_pkg::mag64(64'(a_all[k_q[1:0]]));
			end
			ST_BSQ: begin
				mdu_req.a = w5adv_pkg::mag64(64'(b_all[k_q[1:0]]));
				mdu_req.b = w5adv_pkg::mag64(64'(b_all[k_q[1:0]]));
			end
			ST_QDIV: begin
				mdu_req.div = 1'b1;
				mdu_req.a   = {8'd0, dmin, 16'd0};
				mdu_req.b   = {24'd0, d_q[k_q[1:0]]};
			end
			ST_QSQ: begin
				mdu_req.a = {47'd0, q_q};
				mdu_req.b = {47'd0, q_q};
			end
			ST_OMDIV: begin
				mdu_req.div = 1'b1;
				mdu_req.a   = {13'd0, w_q[k_q[1:0]], 16'd0};
				mdu_req.b   = {28'd0, wsum};
			end
			ST_PHI: begin
				mdu_req.a = {47'd0, om_q};
				mdu_req.b = w5adv_pkg::mag64(64'(data_q[k_q[1:0]]));
				res_mag   = w5adv_pkg::q16_sat(mdu_rsp.prod, w5adv_pkg::PHI_CAP);
				neg_sel   = data_q[k_q[1:0]][52];
			end
			ST_TERM: begin
				mdu_req.a = w5adv_pkg::mag64(64'(vel_q));
				mdu_req.b = w5adv_pkg::mag64(64'(phi_q));
				res_mag   = w5adv_pkg::q16_sat(mdu_rsp.prod, w5adv_pkg::TERM_CAP);
				neg_sel   = vel_q[31] ^ phi_q[55];
			end
			ST_DELTA: begin
				mdu_req.a = w5adv_pkg::mag64(sum_q);
				mdu_req.b = {32'd0, cfg.tstep};
				res_mag   = w5adv_pkg::q16_sat(mdu_rsp.prod, w5adv_pkg::DELTA_CAP);
				neg_sel   = sum_q[63];
			end
			default: op_st = 1'b0;
		endcase
	end

	assign mdu_req.start = op_st && !issued_q;
	assign sgn_res       = w5adv_pkg::with_sign(res_mag, neg_sel);

	assign r_ext = 43'(s_q[3]) - 43'($signed(sgn_res[41:0]));
	always_comb begin
		if (r_ext > 43'sd2147483647) begin
			r_sat = 32'sh7fffffff;
		end else if (r_ext < -43'sd2147483648) begin
			r_sat = 32'sh80000000;
		end else begin
			r_sat = r_ext[31:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= ST_IDLE;
			issued_q    <= 1'b0;
			k_q         <= 3'd0;
			out_valid_q <= 1'b0;
			axial_q     <= 64'sd0;
		end else begin
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (mdu_req.start) begin
				issued_q <= 1'b1;
			end else if (op_done) begin
				issued_q <= 1'b0;
			end
			unique case (st_q)
				ST_IDLE: begin
					if (in_valid) begin
						st_q <= ST_VMUL;
						k_q  <= 3'd0;
					end
				end
				ST_VMUL: begin
					if (op_done && (k_q == 3'd4)) begin
						k_q  <= 3'd0;
						st_q <= ST_NUM;
					end else if (op_done) begin
						k_q <= k_q + 3'd1;
					end
				end
				ST_NUM: st_q <= ST_DMUL;
				ST_DMUL: begin
					if (op_done && (k_q == 3'd2)) begin
						k_q  <= 3'd0;
						st_q <= ST_NORM;
					end else if (op_done) begin
						k_q  <= k_q + 3'd1;
						st_q <= ST_NUM;
					end
				end
				ST_NORM: begin
					if (!norm_big) begin
						st_q <= ST_MU;
					end
				end
				ST_MU: begin
					if (op_done) begin
						st_q <= ST_EPS;
					end
				end
				ST_EPS: begin
					if (op_done) begin
						k_q  <= 3'd0;
						st_q <= ST_ASQ;
					end
				end
				ST_ASQ: begin
					if (op_done) begin
						st_q <= ST_BSQ;
					end
				end
				ST_BSQ: begin
					if (op_done && (k_q == 3'd2)) begin
						k_q  <= 3'd0;
						st_q <= ST_QDIV;
					end else if (op_done) begin
						k_q  <= k_q + 3'd1;
						st_q <= ST_ASQ;
					end
				end
				ST_QDIV: begin
					if (op_done) begin
						st_q <= ST_QSQ;
					end
				end
				ST_QSQ: begin
					if (op_done && (k_q == 3'd2)) begin
						k_q  <= 3'd0;
						st_q <= ST_OMDIV;
					end else if (op_done) begin
						k_q  <= k_q + 3'd1;
						st_q <= ST_QDIV;
					end
				end
				ST_OMDIV: begin
					if (op_done) begin
						st_q <= ST_PHI;
					end
				end
				ST_PHI: begin
					if (op_done && (k_q == 3'd2)) begin
						st_q <= ST_TERM;
					end else if (op_done) begin
						k_q  <= k_q + 3'd1;
						st_q <= ST_OMDIV;
					end
				end
				ST_TERM: begin
					if (op_done && !axis_q) begin
						axial_q <= sgn_res;
						st_q    <= ST_IDLE;
					end else if (op_done) begin
						st_q <= ST_DELTA;
					end
				end
				ST_DELTA: begin
					if (op_done) begin
						st_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (fin_load) begin
						out_valid_q <= 1'b1;
						st_q        <= ST_IDLE;
					end
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			s_q[0] <= sample_m3;
			s_q[1] <= sample_m2;
			s_q[2] <= sample_m1;
			s_q[3] <= sample_center;
			s_q[4] <= sample_p1;
			s_q[5] <= sample_p2;
			s_q[6] <= sample_p3;
			axis_q <= axis;
			vel_q  <= vel_new;
			phi_q  <= 56'sd0;
		end
		if (st_q == ST_NORM && norm_big) begin
			for (int k = 0; k < 5; k++) begin
				vmag_q[k] <= vmag_q[k] >> 1;
			end
		end
		if (st_q == ST_NUM) begin
			num_q <= num_sel;
		end
		if (op_done) begin
			case (st_q)
				ST_VMUL: begin
					vmag_q[k_q] <= mdu_rsp.prod[63:16];
					vneg_q[k_q] <= diff_sel[32];
				end
				ST_DMUL:  data_q[k_q[1:0]] <= sgn_res[52:0];
				ST_MU:    mu2_q <= mdu_rsp.prod[29:0];
				ST_EPS:   eps_q <= mdu_rsp.prod[45:32];
				ST_ASQ:   tacc_q <= 38'(mdu_rsp.prod[33:0]) * 38'd13;
				ST_BSQ: begin
					d_q[k_q[1:0]] <= 40'(tacc_q) + 40'(mdu_rsp.prod[35:0]) * 40'd3
						+ 40'(eps_q) + 40'd1;
				end
				ST_QDIV:  q_q <= mdu_rsp.quo;
				ST_QSQ: begin
					w_q[k_q[1:0]] <= 35'(mdu_rsp.prod[32:0]) * 35'(IDEAL_W[k_q[1:0]]);
				end
				ST_OMDIV: om_q <= mdu_rsp.quo;
				ST_PHI:   phi_q <= phi_q + sgn_res[55:0];
				ST_TERM:  sum_q <= axial_q + sgn_res;
				ST_DELTA: res_q <= r_sat;
				default: ;
			endcase
		end
		if (fin_load) begin
			nv_q <= res_q;
		end
	end

	`W5_ASSERT_IMPL(a_start_when_free, clk, arst_n, mdu_req.start, !mdu_rsp.busy)
	`W5_ASSERT_IMPL(a_done_expected, clk, arst_n, mdu_rsp.done, issued_q)
	`W5_ASSERT_IMPL(a_emit_only_r, clk, arst_n, st_q == ST_FIN, axis_q)
	`W5_ASSERT_IMPL(a_norm_settled, clk, arst_n, st_q == ST_MU, !norm_big)

endmodule

/* hw/rtl/weno5_upwind_advection_step_unit.sv */
// Items are taken one at a time: in_ready is low while one is in work, and z items finish
// sooner than r items, as they stop after the velocity term. An r result may also wait for
// the output register. The shared multiply/divide unit sets the pace: an r item needs
// six 17-step divides and 24 multiplies.
// The result register lets the next item be accepted while a result waits to be taken.
// Reset (arst_n low, asynchronous): idle, no result, stored axial term zero, registers at defaults.
module weno5_upwind_advection_step_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [w5adv_pkg::CFG_AW-1:0]  paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic                          axis,
	input  logic signed [31:0]            sample_m3,
	input  logic signed [31:0]            sample_m2,
	input  logic signed [31:0]            sample_m1,
	input  logic signed [31:0]            sample_center,
	input  logic signed [31:0]            sample_p1,
	input  logic signed [31:0]            sample_p2,
	input  logic signed [31:0]            sample_p3,
	input  logic signed [31:0]            face_vel_here,
	input  logic signed [31:0]            face_vel_below,
	input  logic                          at_low_edge,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic signed [31:0]            new_value
);

	// Step sizes and the time step live in the register block and are read
	// directly by the sequencer; users must see they are only rewritten between items, unchecked.
	w5adv_pkg::cfg_t      cfg;
	w5adv_pkg::mdu_req_t  mdu_req;
	w5adv_pkg::mdu_rsp_t  mdu_rsp;

	w5adv_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// The one arithmetic unit: every product other than those by small constants (derivatives,
	// division by six through a reciprocal, squares, weights, the final scaling) and every
	// quotient of the weight normalization goes through it in turn.
	w5adv_mdu u_mdu (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mdu_req),
		.rsp    (mdu_rsp)
	);

	// The sequencer walks one item through derivatives, candidate stencils,
	// normalization, smoothness indicators, weights and the update. A z item
	// stores its velocity-times-derivative term; an r item adds its own term,
	// scales by the time step and emits the saturated new value.
	w5adv_core u_core (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg            (cfg),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.axis           (axis),
		.sample_m3      (sample_m3),
		.sample_m2      (sample_m2),
		.sample_m1      (sample_m1),
		.sample_center  (sample_center),
		.sample_p1      (sample_p1),
		.sample_p2      (sample_p2),
		.sample_p3      (sample_p3),
		.face_vel_here  (face_vel_here),
		.face_vel_below (face_vel_below),
		.at_low_edge    (at_low_edge),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.new_value      (new_value),
		.mdu_req        (mdu_req),
		.mdu_rsp        (mdu_rsp)
	);

endmodule
